// ===== rtl/tcqg_pkg.sv =====
// Shared constants, codes and types for the tile chunk quad generator
package tcqg_pkg;

    // map, chunk and tile number sizing
    localparam int MAP_SIDE    = 64;
    localparam int CHUNK_SIDE  = 8;
    localparam int TILE_BITS   = 10;
    localparam int STORE_DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IDX_W       = $clog2(MAP_SIDE + 1);
    localparam int LO_BITS     = TILE_BITS / 2;

    // port field widths
    localparam int OPCODE_W   = 2;
    localparam int TADDR_W    = 12;
    localparam int TNUM_W     = 10;
    localparam int VIEW_W     = 14;
    localparam int SLOT_W     = 6;
    localparam int POS_W      = 12;
    localparam int TEXU_W     = 14;
    localparam int TEXV_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // register limits and reset values
    localparam int TILE_PX_MAX  = 64;
    localparam int TSET_MAX     = 256;
    localparam int TILE_RESET   = 32;
    localparam int TSET_RESET   = 8;
    localparam int MAP_RESET    = (MAP_SIDE < 64) ? MAP_SIDE : 64;
    localparam int CHUNK_RESET  = (CHUNK_SIDE < 8) ? CHUNK_SIDE : 8;

    // redraw threshold: move must reach 0.3 of the chunk half-diagonal
    localparam int DIST_SCALE = 100;
    localparam int DIST_LIMIT = 9;

    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [TILE_BITS-1:0] tile_t;
    typedef logic [IDX_W-1:0]     idx_t;

    // request opcodes
    typedef logic [OPCODE_W-1:0] opcode_t;
    localparam opcode_t OP_WRITE  = 2'd0;
    localparam opcode_t OP_MOVE   = 2'd1;
    localparam opcode_t OP_CENTER = 2'd2;

    // register indexes
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_TILE_WIDTH   = 3'd0;
    localparam cfg_idx_t REG_TILE_HEIGHT  = 3'd1;
    localparam cfg_idx_t REG_MAP_WIDTH    = 3'd2;
    localparam cfg_idx_t REG_MAP_HEIGHT   = 3'd3;
    localparam cfg_idx_t REG_CHUNK_WIDTH  = 3'd4;
    localparam cfg_idx_t REG_CHUNK_HEIGHT = 3'd5;
    localparam cfg_idx_t REG_TSET_COLS    = 3'd6;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQUARE,
        ST_SUM,
        ST_SCALE,
        ST_CMP,
        ST_DIV,
        ST_BOUND,
        ST_BASE,
        ST_WALK
    } state_t;

    // per-quad values that travel beside the map read
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic              last;
    } quad_side_t;

endpackage

// ===== rtl/tile_chunk_quad_generator_top.sv =====
// Tile chunk quad generator: tile map memory, move test and quad walk
//
// channel  | dir | handshake            | fields
// ---------+-----+----------------------+----------------------------------------------
// request  | in  | start high, busy low | opcode tile_address tile_number view_x view_y
// result   | out | strobe, one cycle    | quad_slot pos_x pos_y tex_u tex_v last_quad
// config   | in  | cfg_we               | cfg_index cfg_data
//
// map write, center-only and unknown requests are taken while idle and never raise busy.
// a move request runs the distance test in states DIFF, SQUARE, SUM, SCALE and CMP; a move
// below the threshold ends there. a redraw adds a bit-serial division by the doubled tile size
// (x and y side by side), setup in BOUND and BASE, then one map memory read per tile; a chunk
// outside the map ends at BOUND. each result passes the registered read and the quad pipeline.
// busy stays high until the last result is out; results cannot be held off.
// reset restores register defaults and a zero center; map entries hold garbage until written.
module tile_chunk_quad_generator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [tcqg_pkg::OPCODE_W-1:0]       opcode,
    input  logic [tcqg_pkg::TADDR_W-1:0]        tile_address,
    input  logic [tcqg_pkg::TNUM_W-1:0]         tile_number,
    input  logic [tcqg_pkg::VIEW_W-1:0]         view_x,
    input  logic [tcqg_pkg::VIEW_W-1:0]         view_y,
    input  logic                                cfg_we,
    input  logic [tcqg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcqg_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                strobe,
    output logic [tcqg_pkg::SLOT_W-1:0]         quad_slot,
    output logic [tcqg_pkg::POS_W-1:0]          pos_x,
    output logic [tcqg_pkg::POS_W-1:0]          pos_y,
    output logic [tcqg_pkg::TEXU_W-1:0]         tex_u,
    output logic [tcqg_pkg::TEXV_W-1:0]         tex_v,
    output logic                                last_quad
);

    localparam int VW  = tcqg_pkg::VIEW_W;
    localparam int TB  = tcqg_pkg::TILE_BITS;
    localparam int LOB = tcqg_pkg::LO_BITS;
    localparam int IW  = tcqg_pkg::IDX_W;
    localparam int PW  = tcqg_pkg::POS_W;

    // clamp a register write into 1..hi
    function automatic logic [8:0] clamp_cfg(input logic [8:0] v, input logic [8:0] hi);
        logic [8:0] r;
        begin
            r = v;
            if (v == 9'd0) begin
                r = 9'd1;
            end
            else if (v > hi) begin
                r = hi;
            end
            return r;
        end
    endfunction

    // one restoring division step: returns quotient bit over new remainder
    function automatic logic [9:0] div_step(input logic [8:0] rem, input logic bit_in,
                                            input logic [8:0] dvs);
        logic [8:0] sh;
        logic [9:0] r;
        begin
            sh = {rem[7:0], bit_in};
            if (sh >= dvs) begin
                r = {1'b1, sh - dvs};
            end
            else begin
                r = {1'b0, sh};
            end
            return r;
        end
    endfunction

    // configuration registers
    logic [6:0]        tw_reg, th_reg;
    tcqg_pkg::idx_t    mw_reg, mh_reg;
    logic [3:0]        cw_reg, ch_reg;
    logic [8:0]        tc_reg;

    // sequencer and view state
    tcqg_pkg::state_t  state_reg, state_next;
    logic [VW-1:0]     cx_reg, cy_reg;
    logic [VW-1:0]     vx_reg, vy_reg;
    logic [3:0]        div_cnt_reg;

    // distance test datapath
    logic [VW-1:0]     dx_reg, dy_reg;
    logic [9:0]        lx_reg, ly_reg;
    logic [27:0]       dx2_reg, dy2_reg;
    logic [19:0]       lx2_reg, ly2_reg;
    logic [28:0]       d2_reg;
    logic [20:0]       l2_reg;
    logic [35:0]       d100_reg;
    logic [24:0]       l9_reg;
    logic [9:0]        lx_c, ly_c;
    logic              far_enough;

    // corner division
    logic [VW-1:0]     dqx_reg, dqy_reg;
    logic [7:0]        remx_reg, remy_reg;
    logic [7:0]        dvx_reg, dvy_reg;
    logic [8:0]        shx, shy;

    // walk bounds and counters
    logic [VW:0]       rsum, bsum;
    logic              chunk_empty;
    tcqg_pkg::idx_t    left_reg, top_reg, right_reg, bottom_reg;
    tcqg_pkg::idx_t    col_reg, row_reg;
    tcqg_pkg::addr_t   idx_reg, col_addr_reg;
    logic [tcqg_pkg::SLOT_W-1:0] slot_reg, col_slot_reg;
    logic [PW-1:0]     px_reg, py_reg, py_top_reg;
    logic [2*IW-1:0]   top_base_full;
    logic [IW+6:0]     left_px_full, top_py_full;
    logic              row_end, col_end;

    // map memory
    tcqg_pkg::tile_t   tile_mem [tcqg_pkg::STORE_DEPTH];
    tcqg_pkg::tile_t   rd_data_reg;
    logic              mem_we, mem_re;

    // quad pipeline
    logic                 v1_reg, v2_reg, v3_reg;
    tcqg_pkg::quad_side_t s1_reg, s2_reg, s3_reg;
    tcqg_pkg::tile_t      s2_num_reg, s2_q_reg, s3_q_reg;
    logic [8:0]           s2_rem_reg, s3_rem_reg;
    tcqg_pkg::tile_t      q1_c, q2_c;
    logic [8:0]           r1_c, r2_c;
    logic [15:0]          tu_full;
    logic [TB+6:0]        tv_full;

    // output registers
    logic                          strobe_reg, last_reg;
    logic [tcqg_pkg::SLOT_W-1:0]   slot_out_reg;
    logic [PW-1:0]                 pos_x_reg, pos_y_reg;
    logic [tcqg_pkg::TEXU_W-1:0]   tex_u_reg;
    logic [tcqg_pkg::TEXV_W-1:0]   tex_v_reg;

    logic accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != tcqg_pkg::ST_IDLE) || v1_reg || v2_reg || v3_reg;

    // chunk half extents in half pixels
    assign lx_c = {6'b0, cw_reg} * {3'b0, tw_reg};
    assign ly_c = {6'b0, ch_reg} * {3'b0, th_reg};

    assign far_enough = !({11'b0, l9_reg} > d100_reg);

    // corner divider shift values
    assign shx = {remx_reg, dqx_reg[VW-1]};
    assign shy = {remy_reg, dqy_reg[VW-1]};

    // chunk bounds clipped to the map
    assign rsum = {1'b0, dqx_reg} + (VW+1)'(cw_reg);
    assign bsum = {1'b0, dqy_reg} + (VW+1)'(ch_reg);
    assign chunk_empty = (dqx_reg >= VW'(mw_reg)) || (dqy_reg >= VW'(mh_reg));

    // setup products for the first tile
    assign top_base_full = top_reg * mw_reg;
    assign left_px_full  = (IW+7)'(left_reg) * (IW+7)'(tw_reg);
    assign top_py_full   = (IW+7)'(top_reg) * (IW+7)'(th_reg);

    // walk position tests
    assign row_end = (row_reg + tcqg_pkg::idx_t'(1)) == bottom_reg;
    assign col_end = (col_reg + tcqg_pkg::idx_t'(1)) == right_reg;

    assign mem_we = accept && (opcode == tcqg_pkg::OP_WRITE)
                    && (32'(tile_address) < tcqg_pkg::STORE_DEPTH);
    assign mem_re = (state_reg == tcqg_pkg::ST_WALK);

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcqg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcqg_pkg::ST_IDLE:
            begin
                if (accept && (opcode == tcqg_pkg::OP_MOVE))
                begin
                    state_next = tcqg_pkg::ST_DIFF;
                end
            end
            tcqg_pkg::ST_DIFF:   state_next = tcqg_pkg::ST_SQUARE;
            tcqg_pkg::ST_SQUARE: state_next = tcqg_pkg::ST_SUM;
            tcqg_pkg::ST_SUM:    state_next = tcqg_pkg::ST_SCALE;
            tcqg_pkg::ST_SCALE:  state_next = tcqg_pkg::ST_CMP;
            tcqg_pkg::ST_CMP:
            begin
                state_next = far_enough ? tcqg_pkg::ST_DIV : tcqg_pkg::ST_IDLE;
            end
            tcqg_pkg::ST_DIV:
            begin
                if (div_cnt_reg == 4'(VW - 1))
                begin
                    state_next = tcqg_pkg::ST_BOUND;
                end
            end
            tcqg_pkg::ST_BOUND:
            begin
                state_next = chunk_empty ? tcqg_pkg::ST_IDLE : tcqg_pkg::ST_BASE;
            end
            tcqg_pkg::ST_BASE:   state_next = tcqg_pkg::ST_WALK;
            tcqg_pkg::ST_WALK:
            begin
                if (row_end && col_end)
                begin
                    state_next = tcqg_pkg::ST_IDLE;
                end
            end
            default:             state_next = tcqg_pkg::ST_IDLE;
        endcase
    end

    // configuration, center and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tw_reg      <= 7'(tcqg_pkg::TILE_RESET);
            th_reg      <= 7'(tcqg_pkg::TILE_RESET);
            mw_reg      <= tcqg_pkg::idx_t'(tcqg_pkg::MAP_RESET);
            mh_reg      <= tcqg_pkg::idx_t'(tcqg_pkg::MAP_RESET);
            cw_reg      <= 4'(tcqg_pkg::CHUNK_RESET);
            ch_reg      <= 4'(tcqg_pkg::CHUNK_RESET);
            tc_reg      <= 9'(tcqg_pkg::TSET_RESET);
            cx_reg      <= '0;
            cy_reg      <= '0;
            div_cnt_reg <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            strobe_reg  <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tcqg_pkg::REG_TILE_WIDTH:
                        tw_reg <= 7'(clamp_cfg({2'b0, cfg_data[6:0]},
                                               9'(tcqg_pkg::TILE_PX_MAX)));
                    tcqg_pkg::REG_TILE_HEIGHT:
                        th_reg <= 7'(clamp_cfg({2'b0, cfg_data[6:0]},
                                               9'(tcqg_pkg::TILE_PX_MAX)));
                    tcqg_pkg::REG_MAP_WIDTH:
                        mw_reg <= tcqg_pkg::idx_t'(clamp_cfg({2'b0, cfg_data[6:0]},
                                                             9'(tcqg_pkg::MAP_SIDE)));
                    tcqg_pkg::REG_MAP_HEIGHT:
                        mh_reg <= tcqg_pkg::idx_t'(clamp_cfg({2'b0, cfg_data[6:0]},
                                                             9'(tcqg_pkg::MAP_SIDE)));
                    tcqg_pkg::REG_CHUNK_WIDTH:
                        cw_reg <= 4'(clamp_cfg({5'b0, cfg_data[3:0]},
                                               9'(tcqg_pkg::CHUNK_SIDE)));
                    tcqg_pkg::REG_CHUNK_HEIGHT:
                        ch_reg <= 4'(clamp_cfg({5'b0, cfg_data[3:0]},
                                               9'(tcqg_pkg::CHUNK_SIDE)));
                    tcqg_pkg::REG_TSET_COLS:
                        tc_reg <= clamp_cfg(cfg_data, 9'(tcqg_pkg::TSET_MAX));
                    default: ;
                endcase
            end

            // center updates on a set-center request or a move that redraws
            if (accept && (opcode == tcqg_pkg::OP_CENTER))
            begin
                cx_reg <= view_x;
                cy_reg <= view_y;
            end
            else if ((state_reg == tcqg_pkg::ST_CMP) && far_enough)
            begin
                cx_reg <= vx_reg;
                cy_reg <= vy_reg;
            end

            // division step counter
            if (state_reg == tcqg_pkg::ST_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            else
            begin
                div_cnt_reg <= '0;
            end

            // quad pipeline valids
            v1_reg     <= mem_re;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            strobe_reg <= v3_reg;
            last_reg   <= v3_reg && s3_reg.last;
        end
    end

    // setup and walk datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vx_reg <= view_x;
            vy_reg <= view_y;
        end
        unique case (state_reg)
            tcqg_pkg::ST_DIFF:
            begin
                dx_reg <= (vx_reg >= cx_reg) ? vx_reg - cx_reg : cx_reg - vx_reg;
                dy_reg <= (vy_reg >= cy_reg) ? vy_reg - cy_reg : cy_reg - vy_reg;
                lx_reg <= lx_c;
                ly_reg <= ly_c;
            end
            tcqg_pkg::ST_SQUARE:
            begin
                dx2_reg <= {14'b0, dx_reg} * {14'b0, dx_reg};
                dy2_reg <= {14'b0, dy_reg} * {14'b0, dy_reg};
                lx2_reg <= {10'b0, lx_reg} * {10'b0, lx_reg};
                ly2_reg <= {10'b0, ly_reg} * {10'b0, ly_reg};
            end
            tcqg_pkg::ST_SUM:
            begin
                d2_reg <= {1'b0, dx2_reg} + {1'b0, dy2_reg};
                l2_reg <= {1'b0, lx2_reg} + {1'b0, ly2_reg};
            end
            tcqg_pkg::ST_SCALE:
            begin
                d100_reg <= {7'b0, d2_reg} * 36'(tcqg_pkg::DIST_SCALE);
                l9_reg   <= {4'b0, l2_reg} * 25'(tcqg_pkg::DIST_LIMIT);
            end
            tcqg_pkg::ST_CMP:
            begin
                // top-left corner in half pixels, clamped at zero
                dqx_reg  <= (vx_reg > VW'(lx_reg)) ? vx_reg - VW'(lx_reg) : '0;
                dqy_reg  <= (vy_reg > VW'(ly_reg)) ? vy_reg - VW'(ly_reg) : '0;
                remx_reg <= '0;
                remy_reg <= '0;
                dvx_reg  <= {tw_reg, 1'b0};
                dvy_reg  <= {th_reg, 1'b0};
            end
            tcqg_pkg::ST_DIV:
            begin
                // one quotient bit per cycle for both axes
                if (shx >= {1'b0, dvx_reg})
                begin
                    remx_reg <= 8'(shx - {1'b0, dvx_reg});
                    dqx_reg  <= {dqx_reg[VW-2:0], 1'b1};
                end
                else
                begin
                    remx_reg <= shx[7:0];
                    dqx_reg  <= {dqx_reg[VW-2:0], 1'b0};
                end
                if (shy >= {1'b0, dvy_reg})
                begin
                    remy_reg <= 8'(shy - {1'b0, dvy_reg});
                    dqy_reg  <= {dqy_reg[VW-2:0], 1'b1};
                end
                else
                begin
                    remy_reg <= shy[7:0];
                    dqy_reg  <= {dqy_reg[VW-2:0], 1'b0};
                end
            end
            tcqg_pkg::ST_BOUND:
            begin
                left_reg   <= tcqg_pkg::idx_t'(dqx_reg);
                top_reg    <= tcqg_pkg::idx_t'(dqy_reg);
                right_reg  <= (rsum > (VW+1)'(mw_reg)) ? mw_reg : tcqg_pkg::idx_t'(rsum);
                bottom_reg <= (bsum > (VW+1)'(mh_reg)) ? mh_reg : tcqg_pkg::idx_t'(bsum);
            end
            tcqg_pkg::ST_BASE:
            begin
                col_reg      <= left_reg;
                row_reg      <= top_reg;
                col_addr_reg <= tcqg_pkg::addr_t'(top_base_full) + tcqg_pkg::addr_t'(left_reg);
                idx_reg      <= tcqg_pkg::addr_t'(top_base_full) + tcqg_pkg::addr_t'(left_reg);
                slot_reg     <= '0;
                col_slot_reg <= '0;
                px_reg       <= PW'(left_px_full);
                py_reg       <= PW'(top_py_full);
                py_top_reg   <= PW'(top_py_full);
            end
            tcqg_pkg::ST_WALK:
            begin
                // column-major: step down the rows, then to the next column
                if (!row_end)
                begin
                    row_reg  <= row_reg + tcqg_pkg::idx_t'(1);
                    idx_reg  <= idx_reg + tcqg_pkg::addr_t'(mw_reg);
                    slot_reg <= slot_reg + tcqg_pkg::SLOT_W'(cw_reg);
                    py_reg   <= py_reg + PW'(th_reg);
                end
                else
                begin
                    col_reg      <= col_reg + tcqg_pkg::idx_t'(1);
                    row_reg      <= top_reg;
                    col_addr_reg <= col_addr_reg + tcqg_pkg::addr_t'(1);
                    idx_reg      <= col_addr_reg + tcqg_pkg::addr_t'(1);
                    col_slot_reg <= col_slot_reg + tcqg_pkg::SLOT_W'(1);
                    slot_reg     <= col_slot_reg + tcqg_pkg::SLOT_W'(1);
                    px_reg       <= px_reg + PW'(tw_reg);
                    py_reg       <= py_top_reg;
                end
            end
            default: ;
        endcase
    end

    // tile map memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tile_mem[tcqg_pkg::addr_t'(tile_address)] <= tcqg_pkg::tile_t'(tile_number);
        end
        if (mem_re)
        begin
            rd_data_reg <= tile_mem[idx_reg];
        end
    end

    // tile number divide, upper bits
    always_comb
    begin
        logic [8:0] rem;
        logic [9:0] st;
        rem  = '0;
        q1_c = '0;
        for (int i = TB - 1; i >= LOB; i--)
        begin
            st      = div_step(rem, rd_data_reg[i], tc_reg);
            q1_c[i] = st[9];
            rem     = st[8:0];
        end
        r1_c = rem;
    end

    // tile number divide, lower bits
    always_comb
    begin
        logic [8:0] rem;
        logic [9:0] st;
        rem  = s2_rem_reg;
        q2_c = s2_q_reg;
        for (int i = LOB - 1; i >= 0; i--)
        begin
            st      = div_step(rem, s2_num_reg[i], tc_reg);
            q2_c[i] = st[9];
            rem     = st[8:0];
        end
        r2_c = rem;
    end

    // atlas origin products
    assign tu_full = {7'b0, s3_rem_reg} * {9'b0, tw_reg};
    assign tv_full = (TB+7)'(s3_q_reg) * (TB+7)'(th_reg);

    // quad pipeline payload
    always_ff @(posedge clk)
    begin
        s1_reg.slot <= slot_reg;
        s1_reg.px   <= px_reg;
        s1_reg.py   <= py_reg;
        s1_reg.last <= row_end && col_end;

        s2_reg     <= s1_reg;
        s2_num_reg <= rd_data_reg;
        s2_q_reg   <= q1_c;
        s2_rem_reg <= r1_c;

        s3_reg     <= s2_reg;
        s3_q_reg   <= q2_c;
        s3_rem_reg <= r2_c;

        slot_out_reg <= s3_reg.slot;
        pos_x_reg    <= s3_reg.px;
        pos_y_reg    <= s3_reg.py;
        tex_u_reg    <= tcqg_pkg::TEXU_W'(tu_full);
        tex_v_reg    <= tcqg_pkg::TEXV_W'(tv_full);
    end

    assign strobe    = strobe_reg;
    assign quad_slot = slot_out_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign tex_u     = tex_u_reg;
    assign tex_v     = tex_v_reg;
    assign last_quad = last_reg;

    // results only appear while walking or draining after the walk
    a_strobe_phase: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (state_reg == tcqg_pkg::ST_WALK || state_reg == tcqg_pkg::ST_IDLE))
        else $error("result outside walk or drain");

    // final flag marks a real result
    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_quad |-> strobe)
        else $error("last_quad without strobe");

    // nothing follows the final quad of a redraw directly
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last_quad) |=> !strobe)
        else $error("result right after final quad");

    // walk counters stay inside the clipped chunk
    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tcqg_pkg::ST_WALK) |-> (row_reg < bottom_reg && col_reg < right_reg))
        else $error("walk outside chunk bounds");

    // busy covers every map read still in flight
    a_busy_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg || v2_reg || v3_reg) |-> busy)
        else $error("idle with reads in flight");

endmodule

// ===== bench/tcqg_checker.sv =====
// Quad checker: follows requests and register writes, predicts quads, compares the result port
`timescale 1ns / 100ps
module tcqg_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [tcqg_pkg::OPCODE_W-1:0]   opcode,
    input  logic [tcqg_pkg::TADDR_W-1:0]    tile_address,
    input  logic [tcqg_pkg::TNUM_W-1:0]     tile_number,
    input  logic [tcqg_pkg::VIEW_W-1:0]     view_x,
    input  logic [tcqg_pkg::VIEW_W-1:0]     view_y,
    input  logic                            cfg_we,
    input  logic [tcqg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tcqg_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            strobe,
    input  logic [tcqg_pkg::SLOT_W-1:0]     quad_slot,
    input  logic [tcqg_pkg::POS_W-1:0]      pos_x,
    input  logic [tcqg_pkg::POS_W-1:0]      pos_y,
    input  logic [tcqg_pkg::TEXU_W-1:0]     tex_u,
    input  logic [tcqg_pkg::TEXV_W-1:0]     tex_v,
    input  logic                            last_quad,
    output int                              mismatches,
    output int                              outstanding
);
    import tcqg_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
        logic [TEXU_W-1:0] u;
        logic [TEXV_W-1:0] v;
        logic              last;
    } quad_t;

    // shadow copy of the map, the view center and the registers
    tile_t             map_copy [STORE_DEPTH];
    logic [VIEW_W-1:0] cen_x;
    logic [VIEW_W-1:0] cen_y;
    int unsigned       tw, th, mw, mh, cw, ch, tcols;

    // quads predicted but not yet seen on the result port
    quad_t             quad_queue [$];
    quad_t             got;
    quad_t             want;

    function automatic int unsigned clip(input int unsigned v, input int unsigned lo,
                                         input int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // distance test against the stored center, then the column-major chunk walk
    function automatic void redraw_chunk(input int unsigned vx, input int unsigned vy);
        longint unsigned dx, dy, d2, l2;
        int unsigned     cx, cy, lx, ly, tx, ty;
        int unsigned     col0, row0, col_end, row_end, col, row;
        int unsigned     tile, slot_raw, px_raw, py_raw, u_raw, v_raw;
        quad_t           q, prev;
        bit              have_prev;
        cx = cen_x;
        cy = cen_y;
        lx = cw * tw;
        ly = ch * th;
        dx = (vx > cx) ? vx - cx : cx - vx;
        dy = (vy > cy) ? vy - cy : cy - vy;
        d2 = dx * dx + dy * dy;
        l2 = longint'(lx) * lx + longint'(ly) * ly;
        if (100 * d2 < 9 * l2)
            return;
        cen_x = vx[VIEW_W-1:0];
        cen_y = vy[VIEW_W-1:0];
        tx = (vx > lx) ? vx - lx : 0;
        ty = (vy > ly) ? vy - ly : 0;
        col0 = tx / (2 * tw);
        row0 = ty / (2 * th);
        col_end = (col0 + cw > mw) ? mw : col0 + cw;
        row_end = (row0 + ch > mh) ? mh : row0 + ch;
        have_prev = 1'b0;
        prev = '0;
        for (col = col0; col < col_end; col++) begin
            for (row = row0; row < row_end; row++) begin
                tile = map_copy[col + row * mw];
                slot_raw = (col - col0) + (row - row0) * cw;
                px_raw = col * tw;
                py_raw = row * th;
                u_raw = (tile % tcols) * tw;
                v_raw = (tile / tcols) * th;
                q.slot = slot_raw[SLOT_W-1:0];
                q.px = px_raw[POS_W-1:0];
                q.py = py_raw[POS_W-1:0];
                q.u = u_raw[TEXU_W-1:0];
                q.v = v_raw[TEXV_W-1:0];
                q.last = 1'b0;
                // hold one quad back so the final one can be flagged
                if (have_prev)
                    quad_queue.push_back(prev);
                prev = q;
                have_prev = 1'b1;
            end
        end
        if (have_prev) begin
            prev.last = 1'b1;
            quad_queue.push_back(prev);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++)
                map_copy[i] = '0;
            cen_x = '0;
            cen_y = '0;
            tw = TILE_RESET;
            th = TILE_RESET;
            mw = MAP_RESET;
            mh = MAP_RESET;
            cw = CHUNK_RESET;
            ch = CHUNK_RESET;
            tcols = TSET_RESET;
            quad_queue.delete();
            mismatches = 0;
            outstanding <= 0;
        end else begin
            // register writes, clamped into range
            if (cfg_we) begin
                case (cfg_index)
                    REG_TILE_WIDTH:   tw = clip(cfg_data & 9'h07F, 1, TILE_PX_MAX);
                    REG_TILE_HEIGHT:  th = clip(cfg_data & 9'h07F, 1, TILE_PX_MAX);
                    REG_MAP_WIDTH:    mw = clip(cfg_data & 9'h07F, 1, MAP_SIDE);
                    REG_MAP_HEIGHT:   mh = clip(cfg_data & 9'h07F, 1, MAP_SIDE);
                    REG_CHUNK_WIDTH:  cw = clip(cfg_data & 9'h00F, 1, CHUNK_SIDE);
                    REG_CHUNK_HEIGHT: ch = clip(cfg_data & 9'h00F, 1, CHUNK_SIDE);
                    REG_TSET_COLS:    tcols = clip(cfg_data, 1, TSET_MAX);
                    default: ;
                endcase
            end

            // accepted request
            if (start && !busy) begin
                case (opcode)
                    OP_WRITE:
                        if (tile_address < STORE_DEPTH)
                            map_copy[tile_address] = tile_number[TILE_BITS-1:0];
                    OP_CENTER:
                    begin
                        cen_x = view_x;
                        cen_y = view_y;
                    end
                    OP_MOVE:  redraw_chunk(view_x, view_y);
                    default: ;
                endcase
            end

            // result port
            if (strobe) begin
                got = {quad_slot, pos_x, pos_y, tex_u, tex_v, last_quad};
                if (quad_queue.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: quad with none pending: slot %0d x %0d y %0d u %0d v %0d last %0d",
                                 $realtime, got.slot, got.px, got.py, got.u, got.v, got.last);
                    mismatches++;
                end else begin
                    want = quad_queue.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("%0t: quad mismatch: expected slot %0d x %0d y %0d u %0d v %0d last %0d, got slot %0d x %0d y %0d u %0d v %0d last %0d",
                                     $realtime, want.slot, want.px, want.py, want.u,
                                     want.v, want.last, got.slot, got.px, got.py,
                                     got.u, got.v, got.last);
                        mismatches++;
                    end
                end
            end
            outstanding <= quad_queue.size();
        end
    end

endmodule

// ===== bench/testbench.sv =====
// Testbench top: drives map writes, view moves and register settings, reports the verdict
`timescale 1ns / 100ps
module testbench;
    import tcqg_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 120;
    localparam int VIEW_MAX      = (1 << VIEW_W) - 1;

    // codes the block must ignore
    localparam opcode_t  OP_UNUSED  = 2'd3;
    localparam cfg_idx_t REG_UNUSED = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    opcode_t               opcode;
    logic [TADDR_W-1:0]    tile_address;
    logic [TNUM_W-1:0]     tile_number;
    logic [VIEW_W-1:0]     view_x;
    logic [VIEW_W-1:0]     view_y;
    logic                  cfg_we;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  strobe;
    logic [SLOT_W-1:0]     quad_slot;
    logic [POS_W-1:0]      pos_x;
    logic [POS_W-1:0]      pos_y;
    logic [TEXU_W-1:0]     tex_u;
    logic [TEXV_W-1:0]     tex_v;
    logic                  last_quad;
    int                    mismatches;
    int                    outstanding;

    int                    cycles;
    int                    burst_left;
    int                    last_vx;
    int                    last_vy;

    tile_chunk_quad_generator_top dut (.*);

    tcqg_checker u_checker (.*);

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // present one request, wait for it to be taken, then follow the burst pattern
    task automatic issue_request(input opcode_t op, input int addr, input int num,
                                 input int vx, input int vy);
        start <= 1'b1;
        opcode <= op;
        tile_address <= addr[TADDR_W-1:0];
        tile_number <= num[TNUM_W-1:0];
        view_x <= vx[VIEW_W-1:0];
        view_y <= vy[VIEW_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // wait until every predicted quad is out and the block has gone quiet
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    // raw register values, the block clamps them
    task automatic set_config(input int t_w, input int t_h, input int m_w, input int m_h,
                              input int c_w, input int c_h, input int cols);
        write_reg(REG_TILE_WIDTH, t_w);
        write_reg(REG_TILE_HEIGHT, t_h);
        write_reg(REG_MAP_WIDTH, m_w);
        write_reg(REG_MAP_HEIGHT, m_h);
        write_reg(REG_CHUNK_WIDTH, c_w);
        write_reg(REG_CHUNK_HEIGHT, c_h);
        write_reg(REG_TSET_COLS, cols);
        write_reg(REG_UNUSED, 'h1FF);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // random mix of map writes, far and near moves, center sets and unused opcodes
    task automatic run_traffic(input int count, input int span_x, input int span_y);
        int done, pick, addr, num, vx, vy;
        done = 0;
        if (span_x > VIEW_MAX)
            span_x = VIEW_MAX;
        if (span_y > VIEW_MAX)
            span_y = VIEW_MAX;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            addr = $urandom_range(0, STORE_DEPTH - 1);
            num = $urandom_range(0, (1 << TNUM_W) - 1);
            vx = $urandom_range(0, span_x);
            vy = $urandom_range(0, span_y);
            if (pick >= 95) begin
                issue_request(OP_UNUSED, addr, num, vx, vy);
            end else begin
                if (pick < 25) begin
                    // extreme tile numbers now and then
                    if (pick < 4)
                        num = (pick < 2) ? 0 : (1 << TNUM_W) - 1;
                    issue_request(OP_WRITE, addr, num, vx, vy);
                end else begin
                    if (pick >= 68 && pick < 80) begin
                        // small step around the last view, often below the threshold
                        vx = last_vx + int'($urandom_range(0, 48)) - 24;
                        vy = last_vy + int'($urandom_range(0, 48)) - 24;
                        vx = (vx < 0) ? 0 : ((vx > VIEW_MAX) ? VIEW_MAX : vx);
                        vy = (vy < 0) ? 0 : ((vy > VIEW_MAX) ? VIEW_MAX : vy);
                    end else if (pick >= 88) begin
                        vx = $urandom_range(0, VIEW_MAX);
                        vy = $urandom_range(0, VIEW_MAX);
                    end
                    issue_request((pick >= 80 && pick < 88) ? OP_CENTER : OP_MOVE,
                                  addr, num, vx, vy);
                    last_vx = vx;
                    last_vy = vy;
                end
                done++;
            end
        end
    endtask

    initial
    begin
        int a, t_w, t_h, m_w, m_h, c_w, c_h, cols;
        rst_n <= 1'b0;
        start <= 1'b0;
        opcode <= OP_WRITE;
        tile_address <= '0;
        tile_number <= '0;
        view_x <= '0;
        view_y <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_TILE_WIDTH;
        cfg_data <= '0;
        burst_left = 1;
        last_vx = 0;
        last_vy = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole map so no redraw reads an entry that was never written
        for (a = 0; a < STORE_DEPTH; a++)
            issue_request(OP_WRITE, a, $urandom_range(0, (1 << TNUM_W) - 1),
                          $urandom_range(0, VIEW_MAX), $urandom_range(0, VIEW_MAX));

        // directed requests at reset settings: tile 32x32, chunk 8x8, map 64x64
        issue_request(OP_WRITE, 0, (1 << TNUM_W) - 1, 0, 0);
        issue_request(OP_WRITE, STORE_DEPTH - 1, 0, VIEW_MAX, VIEW_MAX);
        issue_request(OP_UNUSED, STORE_DEPTH - 1, (1 << TNUM_W) - 1, VIEW_MAX, VIEW_MAX);
        issue_request(OP_CENTER, 0, 0, VIEW_MAX, VIEW_MAX);
        issue_request(OP_MOVE, 0, 0, 0, 0);
        issue_request(OP_MOVE, 0, 0, 1, 1);
        // chunk entirely outside the map
        issue_request(OP_MOVE, 0, 0, VIEW_MAX, VIEW_MAX);
        // chunk clipped at the bottom-right corner
        issue_request(OP_MOVE, 0, 0, 4095, 4095);
        // either side of the redraw threshold, in both directions
        issue_request(OP_CENTER, 0, 0, 4000, 4000);
        issue_request(OP_MOVE, 0, 0, 4108, 4000);
        issue_request(OP_MOVE, 0, 0, 4109, 4000);
        issue_request(OP_MOVE, 0, 0, 4000, 4000);
        issue_request(OP_MOVE, 0, 0, 4000, 4000);
        // rows past the map, then columns past the map
        issue_request(OP_MOVE, 0, 0, 0, VIEW_MAX);
        issue_request(OP_MOVE, 0, 0, 8191, 0);
        issue_request(OP_MOVE, 0, 0, 2000, 1000);
        last_vx = 2000;
        last_vy = 1000;
        run_traffic(60, 4500, 4500);
        drain();

        // everything at its floor: one-tile map, one-pixel tiles
        set_config(0, 0, 0, 0, 0, 0, 0);
        last_vx = 0;
        last_vy = 0;
        run_traffic(40, 6, 6);
        drain();

        // everything at its ceiling, written with oversized values
        set_config(127, 127, 127, 127, 15, 15, 511);
        run_traffic(60, 9000, 9000);
        drain();

        // single-row map with flat tiles
        set_config(64, 1, 64, 1, 8, 1, 256);
        run_traffic(30, 8400, 40);
        drain();

        // small map that clips a full chunk on both sides
        set_config(16, 8, 5, 3, 8, 8, 3);
        run_traffic(40, 224, 112);
        drain();

        // random settings
        repeat (3) begin
            t_w = $urandom_range(1, TILE_PX_MAX);
            t_h = $urandom_range(1, TILE_PX_MAX);
            m_w = $urandom_range(1, MAP_SIDE);
            m_h = $urandom_range(1, MAP_SIDE);
            c_w = $urandom_range(1, CHUNK_SIDE);
            c_h = $urandom_range(1, CHUNK_SIDE);
            cols = $urandom_range(1, TSET_MAX);
            set_config(t_w, t_h, m_w, m_h, c_w, c_h, cols);
            run_traffic(45, 2 * (m_w + c_w) * t_w, 2 * (m_h + c_h) * t_h);
            drain();
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
